[src/tle_pkg.sv]
// ----------------------------------------------------------------------------
// tle_pkg
// Shared widths, codes, control word layout and microprogram of the terminal
// line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W        = $clog2(LINE_CAPACITY);
    localparam int CHAR_W        = 8;
    localparam int OP_W          = 3;
    localparam int MOVE_W        = 6;
    localparam int MAG_W         = (LEN_W + 1 > MOVE_W + 1) ? LEN_W + 1 : MOVE_W + 1;
    localparam int PC_W          = 5;

    localparam int S_TDATA_W = CHAR_W;
    localparam int S_TUSER_W = 1 + OP_W;
    localparam int M_TDATA_W = ((CHAR_W + MOVE_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - CHAR_W - MOVE_W;

    localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(2 ** (MOVE_W - 1));

    localparam logic [OP_W-1:0] OP_BACKSPACE = OP_W'(1);
    localparam logic [OP_W-1:0] OP_LEFT      = OP_W'(2);
    localparam logic [OP_W-1:0] OP_RIGHT     = OP_W'(3);
    localparam logic [OP_W-1:0] OP_ENTER     = OP_W'(4);

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

    localparam logic KIND_PRINT = 1'b0;
    localparam logic KIND_MOVE  = 1'b1;

    localparam logic [MOVE_W-1:0] MOVE_LEFT_ONE  = {MOVE_W{1'b1}};
    localparam logic [MOVE_W-1:0] MOVE_RIGHT_ONE = MOVE_W'(1);

    typedef enum logic [3:0] {
        COND_NEXT,
        COND_JUMP,
        COND_NO_ACCEPT,
        COND_NO_PRESS,
        COND_CHAR,
        COND_BACKSPACE,
        COND_LEFT,
        COND_RIGHT,
        COND_NOT_ENTER,
        COND_CUR_ZERO,
        COND_CUR_AT_END,
        COND_FULL,
        COND_IDX_AT_END
    } cond_t;

    typedef enum logic [3:0] {
        EM_NONE,
        EM_KEY_CHAR,
        EM_READ_CHAR,
        EM_NEWLINE,
        EM_SPACE,
        EM_MOVE_LEFT,
        EM_MOVE_RIGHT,
        EM_MOVE_TAIL,
        EM_MOVE_TAIL_PLUS1
    } emit_t;

    typedef enum logic [1:0] {
        LST_NO,
        LST_YES,
        LST_IF_NO_TAIL
    } last_t;

    typedef enum logic [1:0] {
        UPD_HOLD,
        UPD_INC,
        UPD_DEC,
        UPD_CLR
    } upd_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_LOAD_CUR,
        IDX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        CARRY_HOLD,
        CARRY_LOAD_KEY,
        CARRY_LOAD_READ
    } carry_op_t;

    typedef enum logic [1:0] {
        MEM_NONE,
        MEM_INSERT,
        MEM_DELETE
    } mem_op_t;

    typedef struct packed {
        cond_t            cond;
        logic [PC_W-1:0]  target;
        logic             accept;
        emit_t            emit;
        last_t            last;
        upd_t             len_op;
        upd_t             cur_op;
        idx_op_t          idx_op;
        carry_op_t        carry_op;
        mem_op_t          mem_op;
    } ctrl_t;

    typedef struct packed {
        logic accepted;
        logic press;
        logic char_nz;
        logic op_backspace;
        logic op_left;
        logic op_right;
        logic op_enter;
        logic cur_zero;
        logic cur_at_end;
        logic full;
        logic idx_at_end;
        logic stall;
    } status_t;

    localparam logic [PC_W-1:0] PC_IDLE      = PC_W'(0);
    localparam logic [PC_W-1:0] PC_DECODE    = PC_W'(1);
    localparam logic [PC_W-1:0] PC_ENTER     = PC_W'(7);
    localparam logic [PC_W-1:0] PC_LEFT      = PC_W'(8);
    localparam logic [PC_W-1:0] PC_RIGHT     = PC_W'(10);
    localparam logic [PC_W-1:0] PC_INSERT    = PC_W'(12);
    localparam logic [PC_W-1:0] PC_INS_LOOP  = PC_W'(14);
    localparam logic [PC_W-1:0] PC_INS_DONE  = PC_W'(16);
    localparam logic [PC_W-1:0] PC_BACKSPACE = PC_W'(19);
    localparam logic [PC_W-1:0] PC_BS_LOOP   = PC_W'(21);
    localparam logic [PC_W-1:0] PC_BS_DONE   = PC_W'(23);

    localparam ctrl_t UW_NOP = '{
        cond:     COND_NEXT,
        target:   PC_IDLE,
        accept:   1'b0,
        emit:     EM_NONE,
        last:     LST_NO,
        len_op:   UPD_HOLD,
        cur_op:   UPD_HOLD,
        idx_op:   IDX_HOLD,
        carry_op: CARRY_HOLD,
        mem_op:   MEM_NONE
    };

    function automatic ctrl_t ucode_word(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = UW_NOP;
        unique case (pc)
            PC_IDLE: begin
                w.cond   = COND_NO_ACCEPT;
                w.target = PC_IDLE;
                w.accept = 1'b1;
            end
            PC_DECODE: begin
                w.cond   = COND_NO_PRESS;
                w.target = PC_IDLE;
            end
            PC_DECODE + PC_W'(1): begin
                w.cond   = COND_CHAR;
                w.target = PC_INSERT;
            end
            PC_DECODE + PC_W'(2): begin
                w.cond   = COND_BACKSPACE;
                w.target = PC_BACKSPACE;
            end
            PC_DECODE + PC_W'(3): begin
                w.cond   = COND_LEFT;
                w.target = PC_LEFT;
            end
            PC_DECODE + PC_W'(4): begin
                w.cond   = COND_RIGHT;
                w.target = PC_RIGHT;
            end
            PC_DECODE + PC_W'(5): begin
                w.cond   = COND_NOT_ENTER;
                w.target = PC_IDLE;
            end
            PC_ENTER: begin
                w.cond   = COND_JUMP;
                w.target = PC_IDLE;
                w.emit   = EM_NEWLINE;
                w.last   = LST_YES;
                w.len_op = UPD_CLR;
                w.cur_op = UPD_CLR;
            end
            PC_LEFT: begin
                w.cond   = COND_CUR_ZERO;
                w.target = PC_IDLE;
            end
            PC_LEFT + PC_W'(1): begin
                w.cond   = COND_JUMP;
                w.target = PC_IDLE;
                w.emit   = EM_MOVE_LEFT;
                w.last   = LST_YES;
                w.cur_op = UPD_DEC;
            end
            PC_RIGHT: begin
                w.cond   = COND_CUR_AT_END;
                w.target = PC_IDLE;
            end
            PC_RIGHT + PC_W'(1): begin
                w.cond   = COND_JUMP;
                w.target = PC_IDLE;
                w.emit   = EM_MOVE_RIGHT;
                w.last   = LST_YES;
                w.cur_op = UPD_INC;
            end
            PC_INSERT: begin
                w.cond   = COND_FULL;
                w.target = PC_IDLE;
            end
            PC_INSERT + PC_W'(1): begin
                w.emit     = EM_KEY_CHAR;
                w.last     = LST_IF_NO_TAIL;
                w.idx_op   = IDX_LOAD_CUR;
                w.carry_op = CARRY_LOAD_KEY;
            end
            PC_INS_LOOP: begin
                w.cond   = COND_IDX_AT_END;
                w.target = PC_INS_DONE;
            end
            PC_INS_LOOP + PC_W'(1): begin
                w.cond     = COND_JUMP;
                w.target   = PC_INS_LOOP;
                w.emit     = EM_READ_CHAR;
                w.idx_op   = IDX_INC;
                w.carry_op = CARRY_LOAD_READ;
                w.mem_op   = MEM_INSERT;
            end
            PC_INS_DONE: begin
                w.mem_op = MEM_INSERT;
                w.len_op = UPD_INC;
                w.cur_op = UPD_INC;
            end
            PC_INS_DONE + PC_W'(1): begin
                w.cond   = COND_CUR_AT_END;
                w.target = PC_IDLE;
            end
            PC_INS_DONE + PC_W'(2): begin
                w.cond   = COND_JUMP;
                w.target = PC_IDLE;
                w.emit   = EM_MOVE_TAIL;
                w.last   = LST_YES;
            end
            PC_BACKSPACE: begin
                w.cond   = COND_CUR_ZERO;
                w.target = PC_IDLE;
            end
            PC_BACKSPACE + PC_W'(1): begin
                w.emit   = EM_MOVE_LEFT;
                w.idx_op = IDX_LOAD_CUR;
            end
            PC_BS_LOOP: begin
                w.cond   = COND_IDX_AT_END;
                w.target = PC_BS_DONE;
            end
            PC_BS_LOOP + PC_W'(1): begin
                w.cond   = COND_JUMP;
                w.target = PC_BS_LOOP;
                w.emit   = EM_READ_CHAR;
                w.idx_op = IDX_INC;
                w.mem_op = MEM_DELETE;
            end
            PC_BS_DONE: begin
                w.len_op = UPD_DEC;
                w.cur_op = UPD_DEC;
            end
            PC_BS_DONE + PC_W'(1): begin
                w.emit = EM_SPACE;
            end
            PC_BS_DONE + PC_W'(2): begin
                w.cond   = COND_JUMP;
                w.target = PC_IDLE;
                w.emit   = EM_MOVE_TAIL_PLUS1;
                w.last   = LST_YES;
            end
            default: begin
                w.cond   = COND_JUMP;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[src/terminal_line_editor_unit.sv]
// ----------------------------------------------------------------------------
// terminal_line_editor_unit
// Line editor for key events that echoes edits as console commands.
//
// Key events enter on the s_ channel and console commands leave on the m_
// channel; both use a valid/ready handshake. One key event gives up to
// LINE_CAPACITY + 2 commands, and m_tlast marks the final one of an event.
// A release, an ignored key or an event with echo off gives no command.
// The block takes one key event at a time: s_tready is high only while the
// sequencer waits at its idle step. Inserting or deleting walks the tail of
// the line through the line store, one read and one write per character.
// Commands are registered: each appears on m_ in the cycle after the
// command step that makes it. When the receiver holds m_tready low, the
// sequencer waits at the step that produces the next command; nothing is
// lost or repeated. Reset clears the line, the cursor and the output valid
// flag and sets echo on; the contents of the line store are not cleared and
// need no clearing.
// ----------------------------------------------------------------------------
module terminal_line_editor_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tle_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] key_char
    input  logic [tle_pkg::S_TUSER_W-1:0]  s_tuser,   // [0] is_press, [3:1] op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tle_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] out_char, [13:8] move_by
    output logic [0:0]                     m_tuser,   // [0] cmd_kind
    output logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data
);
    import tle_pkg::*;

    ctrl_t              ctrl;
    status_t            status;
    logic               cmd_kind;
    logic [CHAR_W-1:0]  out_char;
    logic [MOVE_W-1:0]  move_by;

    tle_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    tle_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .in_is_press  (s_tuser[0]),
        .in_key_char  (s_tdata[CHAR_W-1:0]),
        .in_op        (s_tuser[OP_W:1]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .ctrl         (ctrl),
        .status       (status),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_cmd_kind (cmd_kind),
        .out_char     (out_char),
        .out_move_by  (move_by),
        .out_last     (m_tlast)
    );

    assign s_tready   = ctrl.accept;
    assign m_tdata    = {{M_PAD_W{1'b0}}, move_by, out_char};
    assign m_tuser[0] = cmd_kind;

endmodule

[src/tle_sequencer.sv]
// ----------------------------------------------------------------------------
// tle_sequencer
// Step counter and microprogram store; picks the next step from the jump
// condition of the current control word.
// ----------------------------------------------------------------------------
module tle_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  tle_pkg::status_t  status,
    output tle_pkg::ctrl_t    ctrl
);
    import tle_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;

    always_comb begin
        ctrl = ucode_word(pc_reg);
        unique case (ctrl.cond)
            COND_NEXT:       taken = 1'b0;
            COND_JUMP:       taken = 1'b1;
            COND_NO_ACCEPT:  taken = !status.accepted;
            COND_NO_PRESS:   taken = !status.press;
            COND_CHAR:       taken = status.char_nz;
            COND_BACKSPACE:  taken = status.op_backspace;
            COND_LEFT:       taken = status.op_left;
            COND_RIGHT:      taken = status.op_right;
            COND_NOT_ENTER:  taken = !status.op_enter;
            COND_CUR_ZERO:   taken = status.cur_zero;
            COND_CUR_AT_END: taken = status.cur_at_end;
            COND_FULL:       taken = status.full;
            COND_IDX_AT_END: taken = status.idx_at_end;
            default:         taken = 1'b1;
        endcase
        if (status.stall) begin
            pc_next = pc_reg;
        end else if (taken) begin
            pc_next = ctrl.target;
        end else begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

[src/tle_datapath.sv]
// ----------------------------------------------------------------------------
// tle_datapath
// Line store, length, cursor and walk index, echo register and the output
// register; all but the echo register are driven by the current control word.
// ----------------------------------------------------------------------------
module tle_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        in_is_press,
    input  logic [tle_pkg::CHAR_W-1:0]  in_key_char,
    input  logic [tle_pkg::OP_W-1:0]    in_op,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    input  tle_pkg::ctrl_t              ctrl,
    output tle_pkg::status_t            status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_cmd_kind,
    output logic [tle_pkg::CHAR_W-1:0]  out_char,
    output logic [tle_pkg::MOVE_W-1:0]  out_move_by,
    output logic                        out_last
);
    import tle_pkg::*;

    logic                echo_reg;
    logic                press_reg;
    logic [CHAR_W-1:0]   key_char_reg;
    logic [OP_W-1:0]     op_reg;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    cur_reg, cur_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic [CHAR_W-1:0]   carry_reg, carry_next;
    logic [CHAR_W-1:0]   rd_data_reg;
    logic [CHAR_W-1:0]   line_mem [LINE_CAPACITY];

    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic [MOVE_W-1:0]   out_move_reg, out_move_next;
    logic                out_last_reg, out_last_next;

    logic                emit_on;
    logic                stall;
    logic                go;
    logic                fire;
    logic                accepted;
    logic [LEN_W-1:0]    tail;
    logic [MAG_W-1:0]    mag;
    logic [MAG_W-1:0]    mag_sat;
    logic [MAG_W-1:0]    neg_mag;
    logic [MOVE_W-1:0]   move_tail;
    logic [LEN_W-1:0]    wr_idx;
    logic [CHAR_W-1:0]   wr_data;
    logic                mem_we;

    always_comb begin
        emit_on  = (ctrl.emit != EM_NONE) && echo_reg;
        stall    = emit_on && out_valid_reg && !out_ready;
        go       = !stall;
        fire     = go && emit_on;
        accepted = s_tvalid && ctrl.accept;

        tail    = len_reg - cur_reg;
        mag     = MAG_W'(tail) + ((ctrl.emit == EM_MOVE_TAIL_PLUS1) ? MAG_W'(1) : MAG_W'(0));
        mag_sat = (mag > MAG_LIMIT) ? MAG_LIMIT : mag;
        neg_mag = MAG_W'(0) - mag_sat;
        move_tail = neg_mag[MOVE_W-1:0];

        out_kind_next = KIND_PRINT;
        out_char_next = '0;
        out_move_next = '0;
        unique case (ctrl.emit)
            EM_KEY_CHAR:  out_char_next = key_char_reg;
            EM_READ_CHAR: out_char_next = rd_data_reg;
            EM_NEWLINE:   out_char_next = CHAR_NEWLINE;
            EM_SPACE:     out_char_next = CHAR_SPACE;
            EM_MOVE_LEFT: begin
                out_kind_next = KIND_MOVE;
                out_move_next = MOVE_LEFT_ONE;
            end
            EM_MOVE_RIGHT: begin
                out_kind_next = KIND_MOVE;
                out_move_next = MOVE_RIGHT_ONE;
            end
            EM_MOVE_TAIL, EM_MOVE_TAIL_PLUS1: begin
                out_kind_next = KIND_MOVE;
                out_move_next = move_tail;
            end
            default: out_char_next = '0;
        endcase

        unique case (ctrl.last)
            LST_YES:        out_last_next = 1'b1;
            LST_IF_NO_TAIL: out_last_next = (cur_reg == len_reg);
            default:        out_last_next = 1'b0;
        endcase

        if (fire) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        len_next = len_reg;
        if (go) begin
            unique case (ctrl.len_op)
                UPD_INC: len_next = len_reg + LEN_W'(1);
                UPD_DEC: len_next = len_reg - LEN_W'(1);
                UPD_CLR: len_next = '0;
                default: len_next = len_reg;
            endcase
        end

        cur_next = cur_reg;
        if (go) begin
            unique case (ctrl.cur_op)
                UPD_INC: cur_next = cur_reg + LEN_W'(1);
                UPD_DEC: cur_next = cur_reg - LEN_W'(1);
                UPD_CLR: cur_next = '0;
                default: cur_next = cur_reg;
            endcase
        end

        idx_next = idx_reg;
        if (go) begin
            unique case (ctrl.idx_op)
                IDX_LOAD_CUR: idx_next = cur_reg;
                IDX_INC:      idx_next = idx_reg + LEN_W'(1);
                default:      idx_next = idx_reg;
            endcase
        end

        carry_next = carry_reg;
        if (go) begin
            unique case (ctrl.carry_op)
                CARRY_LOAD_KEY:  carry_next = key_char_reg;
                CARRY_LOAD_READ: carry_next = rd_data_reg;
                default:         carry_next = carry_reg;
            endcase
        end

        mem_we  = go && (ctrl.mem_op != MEM_NONE);
        wr_idx  = (ctrl.mem_op == MEM_DELETE) ? idx_reg - LEN_W'(1) : idx_reg;
        wr_data = (ctrl.mem_op == MEM_DELETE) ? rd_data_reg : carry_reg;

        status.accepted     = accepted;
        status.press        = press_reg;
        status.char_nz      = (key_char_reg != '0);
        status.op_backspace = (op_reg == OP_BACKSPACE);
        status.op_left      = (op_reg == OP_LEFT);
        status.op_right     = (op_reg == OP_RIGHT);
        status.op_enter     = (op_reg == OP_ENTER);
        status.cur_zero     = (cur_reg == '0);
        status.cur_at_end   = (cur_reg == len_reg);
        status.full         = (len_reg == LEN_W'(LINE_CAPACITY));
        status.idx_at_end   = (idx_reg == len_reg);
        status.stall        = stall;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_reg      <= 1'b1;
            len_reg       <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                echo_reg <= cfg_wr_data;
            end
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accepted) begin
            press_reg    <= in_is_press;
            key_char_reg <= in_key_char;
            op_reg       <= in_op;
        end
        idx_reg   <= idx_next;
        carry_reg <= carry_next;
        if (fire) begin
            out_kind_reg <= out_kind_next;
            out_char_reg <= out_char_next;
            out_move_reg <= out_move_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[wr_idx[ADDR_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= line_mem[idx_reg[ADDR_W-1:0]];
    end

    assign out_valid    = out_valid_reg;
    assign out_cmd_kind = out_kind_reg;
    assign out_char     = out_char_reg;
    assign out_move_by  = out_move_reg;
    assign out_last     = out_last_reg;

endmodule

[tb/terminal_line_editor_unit_test.sv]
// ----------------------------------------------------------------------------
// terminal_line_editor_unit_test
// Self-checking testbench for the terminal line editor. Key events are sent
// on the s_ channel and every console command on the m_ channel is checked,
// in order, against commands worked out by a line model kept in this file.
// Directed tests cover ignored keys, edits in the middle and at the ends of
// the line, a full line and echo switched off; random edit sessions follow,
// with both channels idling at random apart from one steady stretch.
// ----------------------------------------------------------------------------
module terminal_line_editor_unit_test;
    import tle_pkg::*;

    localparam logic [OP_W-1:0] OP_OTHER    = '0;
    localparam logic [OP_W-1:0] OP_TOP      = '1;
    localparam int              SETTLE      = 2 * LINE_CAPACITY + 20;
    localparam int unsigned     CYCLE_LIMIT = 1000000;
    localparam int              MAX_REPORTS = 100;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] ch;
        logic [MOVE_W-1:0] move;
        logic              last;
    } console_cmd_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic [S_TUSER_W-1:0]  s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en   = 1'b0;
    logic                  cfg_wr_data = 1'b0;

    logic [CHAR_W-1:0] line_chars [LINE_CAPACITY];
    int                line_len   = 0;
    int                cursor     = 0;
    logic              echo_on    = 1'b1;
    console_cmd_t      console_cmds [$];
    int                mismatches = 0;
    bit                steady     = 1'b0;
    int unsigned       cycle_count = 0;

    terminal_line_editor_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    function automatic console_cmd_t print_cmd(input logic [CHAR_W-1:0] ch);
        console_cmd_t c;
        c = '{kind: KIND_PRINT, ch: ch, move: '0, last: 1'b0};
        return c;
    endfunction

    function automatic console_cmd_t move_cmd(input int by);
        console_cmd_t c;
        if (by < -(2 ** (MOVE_W - 1))) by = -(2 ** (MOVE_W - 1));
        if (by > 2 ** (MOVE_W - 1) - 1) by = 2 ** (MOVE_W - 1) - 1;
        c = '{kind: KIND_MOVE, ch: '0, move: MOVE_W'(by), last: 1'b0};
        return c;
    endfunction

    // Applies one key event to the line and queues the commands it echoes.
    task automatic edit_line(input logic press, input logic [CHAR_W-1:0] ch,
                             input logic [OP_W-1:0] op);
        console_cmd_t burst [$];
        int i;
        if (!press) return;
        if (ch != '0) begin
            if (line_len >= LINE_CAPACITY) return;
            for (i = line_len; i > cursor; i--) line_chars[i] = line_chars[i - 1];
            line_chars[cursor] = ch;
            cursor++;
            line_len++;
            if (echo_on) begin
                burst.push_back(print_cmd(ch));
                for (i = cursor; i < line_len; i++) burst.push_back(print_cmd(line_chars[i]));
                if (line_len > cursor) burst.push_back(move_cmd(cursor - line_len));
            end
        end else if (op == OP_BACKSPACE) begin
            if (cursor == 0) return;
            for (i = cursor - 1; i + 1 < line_len; i++) line_chars[i] = line_chars[i + 1];
            cursor--;
            line_len--;
            if (echo_on) begin
                burst.push_back(move_cmd(-1));
                for (i = cursor; i < line_len; i++) burst.push_back(print_cmd(line_chars[i]));
                burst.push_back(print_cmd(CHAR_SPACE));
                burst.push_back(move_cmd(cursor - line_len - 1));
            end
        end else if (op == OP_LEFT) begin
            if (cursor > 0) begin
                cursor--;
                if (echo_on) burst.push_back(move_cmd(-1));
            end
        end else if (op == OP_RIGHT) begin
            if (cursor < line_len) begin
                cursor++;
                if (echo_on) burst.push_back(move_cmd(1));
            end
        end else if (op == OP_ENTER) begin
            if (echo_on) burst.push_back(print_cmd(CHAR_NEWLINE));
            line_len = 0;
            cursor = 0;
        end
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k]) console_cmds.push_back(burst[k]);
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS) $display("mismatch: %s", what);
        mismatches++;
    endtask

    task automatic send_key(input logic press, input logic [CHAR_W-1:0] ch,
                            input logic [OP_W-1:0] op);
        while (!steady && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= {op, press};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        edit_line(press, ch, op);
    endtask

    // Waits for every queued command, then for the block to finish any
    // event that echoes nothing.
    task automatic drain_output();
        s_tvalid <= 1'b0;
        while (console_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_echo(input logic value);
        drain_output();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        echo_on = value;
    endtask

    task automatic test_ignored_keys();
        send_key(1'b1, '0, OP_ENTER);
        send_key(1'b1, '0, OP_BACKSPACE);
        send_key(1'b1, '0, OP_LEFT);
        send_key(1'b1, '0, OP_RIGHT);
        send_key(1'b0, "a", OP_OTHER);
        send_key(1'b0, '0, OP_ENTER);
        send_key(1'b1, '0, OP_OTHER);
        send_key(1'b1, '0, OP_TOP);
    endtask

    task automatic test_insert_delete();
        send_key(1'b1, 8'hFF, OP_ENTER);
        send_key(1'b1, 8'h01, OP_BACKSPACE);
        send_key(1'b1, "b", OP_TOP);
        send_key(1'b1, '0, OP_LEFT);
        send_key(1'b1, '0, OP_LEFT);
        send_key(1'b1, "c", OP_OTHER);
        send_key(1'b1, '0, OP_RIGHT);
        send_key(1'b1, '0, OP_BACKSPACE);
        send_key(1'b0, "z", OP_BACKSPACE);
        send_key(1'b1, '0, OP_RIGHT);
        send_key(1'b1, '0, OP_RIGHT);
        send_key(1'b1, '0, OP_BACKSPACE);
        send_key(1'b1, '0, OP_LEFT);
        send_key(1'b1, '0, OP_ENTER);
    endtask

    task automatic test_full_line();
        repeat (LINE_CAPACITY) send_key(1'b1, CHAR_W'($urandom_range(1, 255)), OP_OTHER);
        send_key(1'b1, "q", OP_OTHER);
        repeat (LINE_CAPACITY - 1) send_key(1'b1, '0, OP_LEFT);
        send_key(1'b1, '0, OP_BACKSPACE);
        send_key(1'b1, CHAR_W'($urandom_range(1, 255)), OP_LEFT);
        send_key(1'b1, CHAR_W'($urandom_range(1, 255)), OP_RIGHT);
        send_key(1'b1, '0, OP_ENTER);
    endtask

    task automatic test_echo_off();
        set_echo(1'b0);
        repeat (6) send_key(1'b1, CHAR_W'($urandom_range(1, 255)), OP_OTHER);
        repeat (3) send_key(1'b1, '0, OP_LEFT);
        send_key(1'b1, '0, OP_BACKSPACE);
        send_key(1'b1, '0, OP_RIGHT);
        set_echo(1'b1);
        send_key(1'b1, "x", OP_OTHER);
        send_key(1'b1, '0, OP_BACKSPACE);
        send_key(1'b1, '0, OP_ENTER);
    endtask

    // Mostly presses that edit the line, with some releases and dead keys.
    task automatic test_random_edits(input int edits, input logic echo,
                                     input bit no_idle);
        int done;
        int pick;
        done = 0;
        set_echo(echo);
        steady = no_idle;
        while (done < edits) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_key(1'b0, CHAR_W'($urandom), OP_W'($urandom));
            end else if (pick < 12) begin
                send_key(1'b1, '0, ($urandom_range(1) == 0) ? OP_OTHER :
                         OP_W'($urandom_range(int'(OP_ENTER) + 1, int'(OP_TOP))));
            end else begin
                if (pick < 55)
                    send_key(1'b1, CHAR_W'($urandom_range(1, 255)), OP_W'($urandom));
                else if (pick < 68)
                    send_key(1'b1, '0, OP_BACKSPACE);
                else if (pick < 81)
                    send_key(1'b1, '0, OP_LEFT);
                else if (pick < 94)
                    send_key(1'b1, '0, OP_RIGHT);
                else
                    send_key(1'b1, '0, OP_ENTER);
                done++;
            end
        end
        drain_output();
        steady = 1'b0;
    endtask

    always @(posedge aclk) begin
        console_cmd_t seen;
        console_cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = '{kind: m_tuser[0], ch: m_tdata[CHAR_W-1:0],
                     move: m_tdata[CHAR_W +: MOVE_W], last: m_tlast};
            if (console_cmds.size() == 0) begin
                report_mismatch($sformatf("unexpected command %h", seen));
            end else begin
                want = console_cmds.pop_front();
                if (seen.kind !== want.kind || seen.ch !== want.ch ||
                    seen.move !== want.move || seen.last !== want.last)
                    report_mismatch($sformatf(
                        "kind %b/%b char %h/%h move %h/%h last %b/%b (got/expected)",
                        seen.kind, want.kind, seen.ch, want.ch,
                        seen.move, want.move, seen.last, want.last));
            end
        end
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 11);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[terminal_line_editor_unit] ERROR");
        $finish;
    end

    initial begin
        foreach (line_chars[k]) line_chars[k] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_ignored_keys();
        test_insert_delete();
        test_full_line();
        test_echo_off();
        test_random_edits(110, 1'b1, 1'b0);
        test_random_edits(40, 1'b0, 1'b0);
        test_random_edits(90, 1'b1, 1'b1);
        test_random_edits(110, 1'b1, 1'b0);
        drain_output();
        if (mismatches == 0)
            $display("[terminal_line_editor_unit] OK");
        else
            $display("[terminal_line_editor_unit] ERROR");
        $finish;
    end

endmodule
